>>> rtl/core/blist_pkg.sv
// Package for the bounded sequence list: request codes, status codes and the
// command word that the controller broadcasts to the row of storage cells.
// No dependencies.
package blist_pkg;

  localparam int OPER_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;

  // Widest cell index for the largest supported capacity of 4096 entries.
  localparam int IDX_MAX_W = 12;

  localparam logic [OPER_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OPER_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OPER_W-1:0] OP_DELETE    = 3'd2;
  localparam logic [OPER_W-1:0] OP_SEARCH    = 3'd3;
  localparam logic [OPER_W-1:0] OP_REVERSE   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_IN,
    CMD_LOAD,
    CMD_SHIFT_OUT,
    CMD_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e            cmd;
    logic [IDX_MAX_W-1:0] target;
    logic [IDX_MAX_W-1:0] last;
  } cell_ctl_t;

endpackage

>>> rtl/core/blist_if.sv
// Request and response channel interfaces of the bounded sequence list.
// Depends on blist_pkg for the field widths.
interface blist_req_if;
  logic                                valid;
  logic                                ready;
  logic        [blist_pkg::OPER_W-1:0] operation;
  logic signed [blist_pkg::VALUE_W-1:0] value;
  logic        [blist_pkg::POS_W-1:0]  position;

  modport source (output valid, output operation, output value, output position, input ready);
  modport sink   (input valid, input operation, input value, input position, output ready);
endinterface

interface blist_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic        [blist_pkg::STATUS_W-1:0] status;
  logic        [blist_pkg::POS_W-1:0]    location;
  logic        [blist_pkg::POS_W-1:0]    count;

  modport source (output valid, output status, output location, output count, input ready);
  modport sink   (input valid, input status, input location, input count, output ready);
endinterface

>>> rtl/core/blist_cell.sv
// One storage cell of the list row: holds one entry and takes the value of a
// neighbour, the write data or the first cell as the broadcast command says.
// Depends on blist_pkg.
module blist_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  blist_pkg::cell_ctl_t  ctl_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] first_i,
  output logic [DATA_WIDTH-1:0] data_o
);
  import blist_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MyIdx = IDX_MAX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.cmd)
      CMD_HOLD:     data_d = data_q;
      CMD_SHIFT_IN: data_d = left_i;
      CMD_LOAD: begin
        if (MyIdx == ctl_i.target) data_d = wdata_i;
      end
      CMD_SHIFT_OUT: begin
        if (MyIdx >= ctl_i.target) data_d = right_i;
      end
      CMD_ROTATE: begin
        if (MyIdx < ctl_i.last) begin
          data_d = right_i;
        end else if (MyIdx == ctl_i.last) begin
          data_d = first_i;
        end
      end
      default:      data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> rtl/core/bounded_sequence_list.sv
// Bounded sequence list: an ordered list of up to CAPACITY signed words kept
// in a row of storage cells. Depends on blist_pkg, blist_if and blist_cell.
//
// Requests arrive on req_i (operation, value, position) and each one gives a
// single response on rsp_o (status, location, count) with valid/ready
// handshakes. One request is in work at a time.
// Insert, delete and reverse finish in the cycle of acceptance; the response
// is registered and visible in the next cycle. Delete moves each following
// entry one cell in the same cycle, as each cell takes its neighbour's word.
// Search rotates the stored entries through the row, one entry past the
// comparator in cell 0 per cycle, and the response follows in the cycle
// after the last comparison; the rotation puts each entry back in its cell.
// Reversal only flips a direction bit; cell 0 then holds the last position.
// A new request is taken while the response register is empty or being read,
// so a stalled receiver holds off further requests without losing results.
// After reset the list is empty and the order is forward; the cell contents
// are not cleared, as no entry is read before it is written.
module bounded_sequence_list #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  blist_req_if.sink   req_i,
  blist_rsp_if.source rsp_o
);
  import blist_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  rev_q, rev_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [CntW-1:0]       step_q, step_d;
  logic                  found_q, found_d;
  logic [CntW-1:0]       loc_q, loc_d;

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [POS_W-1:0]      out_loc_q, out_loc_d;
  logic [POS_W-1:0]      out_count_q, out_count_d;

  logic                  accept;
  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] word;
  logic [CmpW-1:0]       pos_ext;
  logic [CmpW-1:0]       cnt_ext;
  logic [CntW-1:0]       pos_c;
  logic                  done;
  logic                  hit;
  logic [STATUS_W-1:0]   res_status;
  logic [CntW-1:0]       res_loc;
  cell_ctl_t             ctl;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign value_ext = {{32{req_i.value[VALUE_W-1]}}, req_i.value};
  assign word      = value_ext[DATA_WIDTH-1:0];
  assign pos_ext   = CmpW'(req_i.position);
  assign cnt_ext   = CmpW'(count_q);
  assign pos_c     = CntW'(req_i.position);
  assign hit       = (cell_data[0] == key_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rev_d      = rev_q;
    key_d      = key_q;
    step_d     = step_q;
    found_d    = found_q;
    loc_d      = loc_q;
    done       = 1'b0;
    res_status = STAT_OK;
    res_loc    = '0;
    ctl.cmd    = CMD_HOLD;
    ctl.target = '0;
    ctl.last   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.operation)
            OP_INS_FRONT, OP_INS_BACK: begin
              done = 1'b1;
              if (count_q == CntW'(CAPACITY)) begin
                res_status = STAT_FULL;
              end else begin
                if ((req_i.operation == OP_INS_FRONT) != rev_q) begin
                  ctl.cmd = CMD_SHIFT_IN;
                end else begin
                  ctl.cmd    = CMD_LOAD;
                  ctl.target = IDX_MAX_W'(count_q);
                end
                count_d = count_q + 1'b1;
              end
            end
            OP_DELETE: begin
              done = 1'b1;
              if (count_q == '0) begin
                res_status = STAT_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                res_status = STAT_BADPOS;
              end else begin
                ctl.cmd    = CMD_SHIFT_OUT;
                ctl.target = rev_q ? IDX_MAX_W'(count_q - pos_c)
                                   : IDX_MAX_W'(pos_c - 1'b1);
                count_d    = count_q - 1'b1;
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                done       = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                state_d = S_SCAN;
                key_d   = word;
                step_d  = '0;
                found_d = 1'b0;
                loc_d   = '0;
              end
            end
            OP_REVERSE: begin
              done = 1'b1;
              if (count_q == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                rev_d = !rev_q;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.cmd  = CMD_ROTATE;
        ctl.last = IDX_MAX_W'(count_q - 1'b1);
        if (hit && (rev_q || !found_q)) begin
          found_d = 1'b1;
          loc_d   = rev_q ? (count_q - step_q) : (step_q + 1'b1);
        end
        if (step_q == count_q - 1'b1) begin
          done       = 1'b1;
          state_d    = S_IDLE;
          res_status = found_d ? STAT_OK : STAT_NOTFOUND;
          res_loc    = found_d ? loc_d : '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_loc_d    = out_loc_q;
    out_count_d  = out_count_q;
    if (done) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status;
      out_loc_d    = POS_W'(res_loc);
      out_count_d  = POS_W'(count_d);
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rev_q       <= 1'b0;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      step_q      <= step_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    loc_q        <= loc_d;
    out_status_q <= out_status_d;
    out_loc_q    <= out_loc_d;
    out_count_q  <= out_count_d;
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.location = out_loc_q;
  assign rsp_o.count    = out_count_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_data = word;
    end else begin : g_body
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    blist_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .wdata_i (word),
      .left_i  (left_data),
      .right_i (right_data),
      .first_i (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

endmodule

>>> tb/bounded_sequence_list_checker.sv
`timescale 1ns / 100ps
// Checker for the bounded sequence list: watches the request and response channels,
// keeps its own copy of the list and compares each response with the expected one.
// Depends on blist_pkg and the channel interfaces in blist_if.
module bounded_sequence_list_checker #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  blist_req_if  req_i,
  blist_rsp_if  rsp_i,
  output int    fail_count_o,
  output int    pending_o,
  output int    checked_o
);
  import blist_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    location;
    logic [POS_W-1:0]    count;
  } list_reply_t;

  logic [DATA_WIDTH-1:0] words_q [CAPACITY];
  int                    head_q;
  int                    size_q;
  bit                    backward_q;
  list_reply_t           replies_q [$];

  function automatic int slot_at(int k);
    int step;
    step = ((k % CAPACITY) + CAPACITY) % CAPACITY;
    if (backward_q) begin
      return (head_q + CAPACITY - step) % CAPACITY;
    end
    return (head_q + step) % CAPACITY;
  endfunction

  task automatic apply_request(input logic [OPER_W-1:0] op,
                               input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] position,
                               output list_reply_t reply);
    logic [DATA_WIDTH-1:0] word;
    int                    pos;
    int                    slot;
    word  = value[DATA_WIDTH-1:0];
    pos   = int'(position);
    reply = '{status: STAT_OK, location: '0, count: '0};
    case (op)
      OP_INS_FRONT: begin
        if (size_q >= CAPACITY) begin
          reply.status = STAT_FULL;
        end else begin
          slot          = slot_at(-1);
          words_q[slot] = word;
          head_q        = slot;
          size_q++;
        end
      end
      OP_INS_BACK: begin
        if (size_q >= CAPACITY) begin
          reply.status = STAT_FULL;
        end else begin
          words_q[slot_at(size_q)] = word;
          size_q++;
        end
      end
      OP_DELETE: begin
        if (size_q == 0) begin
          reply.status = STAT_EMPTY;
        end else if (pos == 0 || pos > size_q) begin
          reply.status = STAT_BADPOS;
        end else begin
          for (int i = pos - 1; i + 1 < size_q; i++) begin
            words_q[slot_at(i)] = words_q[slot_at(i + 1)];
          end
          size_q--;
        end
      end
      OP_SEARCH: begin
        if (size_q == 0) begin
          reply.status = STAT_EMPTY;
        end else begin
          reply.status = STAT_NOTFOUND;
          for (int i = 0; i < size_q; i++) begin
            if (reply.status == STAT_NOTFOUND && words_q[slot_at(i)] == word) begin
              reply.status   = STAT_OK;
              reply.location = POS_W'(i + 1);
            end
          end
        end
      end
      OP_REVERSE: begin
        if (size_q == 0) begin
          reply.status = STAT_EMPTY;
        end else begin
          head_q     = slot_at(size_q - 1);
          backward_q = !backward_q;
        end
      end
      default: begin
      end
    endcase
    reply.count = POS_W'(size_q);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    list_reply_t fresh;
    if (!rst_ni) begin
      head_q       = 0;
      size_q       = 0;
      backward_q   = 1'b0;
      replies_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // The response accepted at this edge always belongs to an earlier request.
      if (rsp_i.valid && rsp_i.ready) begin
        if (replies_q.size() == 0) begin
          $error("Response transaction with no request outstanding: status %0d",
                 rsp_i.status);
          fail_count_o++;
        end else begin
          want = replies_q.pop_front();
          checked_o++;
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_i.status);
            fail_count_o++;
          end
          if (rsp_i.location !== want.location) begin
            $error("location: expected %0d, actual %0d", want.location, rsp_i.location);
            fail_count_o++;
          end
          if (rsp_i.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp_i.count);
            fail_count_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        apply_request(req_i.operation, req_i.value, req_i.position, fresh);
        replies_q.push_back(fresh);
      end
      pending_o = replies_q.size();
    end
  end

endmodule

>>> tb/bounded_sequence_list_test.sv
`timescale 1ns / 100ps
// Testbench top for the bounded sequence list: clock, reset, request stimulus with
// random gaps and response stalls, and the verdict. Depends on blist_pkg, blist_if,
// the block itself and bounded_sequence_list_checker.
module bounded_sequence_list_test;
  import blist_pkg::*;

  localparam int LIST_CAP    = 64;
  localparam int RANDOM_REQS = 1450;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 2 * LIST_CAP + 8;

  localparam logic [OPER_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPER_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [VALUE_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] WORD_ONES = 32'hffff_ffff;

  logic clk_i;
  logic rst_ni;

  blist_req_if req_ch ();
  blist_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int checked;

  bit                calm;
  int                stall_left;
  int                cycles;
  int                list_len;
  int                sent_by_op [8];
  logic [VALUE_W-1:0] seen_vals [16];
  int                seen_wr;

  bounded_sequence_list #(
    .CAPACITY  (LIST_CAP),
    .DATA_WIDTH(32)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  bounded_sequence_list_checker #(
    .CAPACITY  (LIST_CAP),
    .DATA_WIDTH(32)
  ) u_list_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pick_hold();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        2:       return '0;
        default: return WORD_ONES;
      endcase
    end else if (r < 4) begin
      return VALUE_W'($signed($urandom_range(0, 20)) - 10);
    end
    return $urandom;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_search();
    if ($urandom_range(0, 9) < 6) begin
      return seen_vals[$urandom_range(0, 15)];
    end
    return pick_value();
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (list_len > 0 && $urandom_range(0, 9) < 8) begin
      return POS_W'($urandom_range(1, list_len));
    end
    return POS_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [OPER_W-1:0] pick_spare_op();
    return OPER_W'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
  endfunction

  // Response side: ready held high or low for random stretches, high when calm.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(0, 2) != 0);
      stall_left   <= pick_hold();
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d responses outstanding.", pending);
      $display("bounded_sequence_list_test: FAIL");
      $finish;
    end
  end

  task automatic send_req(input logic [OPER_W-1:0] op, input logic [VALUE_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int gap;
    gap = calm ? 0 : pick_hold();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= val;
    req_ch.position  <= pos;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_by_op[op]++;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (list_len < LIST_CAP) begin
          list_len++;
          seen_vals[seen_wr % 16] = val;
          seen_wr++;
        end
      end
      OP_DELETE: begin
        if (pos >= 1 && pos <= list_len) begin
          list_len--;
        end
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    int                 done;
    int                 phase_left;
    int                 phase_no;
    int                 r;
    logic [OPER_W-1:0]  op;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0]   pos;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_INS_FRONT;
    req_ch.value     = '0;
    req_ch.position  = '0;
    rsp_ch.ready     = 1'b0;
    calm             = 1'b0;
    stall_left       = 0;
    cycles           = 0;
    list_len         = 0;
    seen_wr          = 0;
    foreach (sent_by_op[i]) sent_by_op[i] = 0;
    foreach (seen_vals[i]) seen_vals[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list cases, unused codes, extreme words and bad positions.
    send_req(OP_SEARCH, '0, '0);
    send_req(OP_DELETE, '0, 7'd1);
    send_req(OP_REVERSE, '0, '0);
    send_req(OP_SPARE_LO, WORD_ONES, 7'd127);
    send_req(OP_SPARE_HI, '0, '0);
    send_req(OP_INS_FRONT, WORD_MIN, '0);
    send_req(OP_INS_BACK, WORD_MAX, '0);
    send_req(OP_INS_FRONT, '0, '0);
    send_req(OP_INS_BACK, WORD_ONES, '0);
    send_req(OP_INS_BACK, '0, '0);
    send_req(OP_SEARCH, '0, '0);
    send_req(OP_SEARCH, 32'd12345, '0);
    send_req(OP_SEARCH, WORD_MAX, '0);
    send_req(OP_DELETE, '0, 7'd0);
    send_req(OP_DELETE, '0, 7'd127);
    send_req(OP_DELETE, '0, 7'd6);
    send_req(OP_REVERSE, '0, '0);
    send_req(OP_SEARCH, WORD_MIN, '0);
    send_req(OP_DELETE, '0, 7'd5);
    send_req(OP_DELETE, '0, 7'd1);
    send_req(OP_REVERSE, '0, '0);
    send_req(OP_SEARCH, WORD_ONES, '0);
    send_req(OP_INS_FRONT, 32'h5a5a_a5a5, '0);
    send_req(OP_DELETE, '0, 7'd2);

    // Random part in phases that fill, mix and drain the list in turn.
    done       = 0;
    phase_left = 0;
    phase_no   = -1;
    while (done < RANDOM_REQS) begin
      if (phase_left == 0) begin
        phase_no++;
        phase_left = $urandom_range(60, 160);
        calm       = ($urandom_range(0, 3) == 0);
      end
      r   = $urandom_range(0, 99);
      val = pick_value();
      pos = POS_W'($urandom_range(0, 127));
      if (r < 2) begin
        op = pick_spare_op();
      end else begin
        r = $urandom_range(0, 99);
        case (phase_no % 3)
          0: op = (r < 75) ? ((r % 2) ? OP_INS_BACK : OP_INS_FRONT) :
                  (r < 80) ? OP_DELETE : (r < 92) ? OP_SEARCH : OP_REVERSE;
          1: op = (r < 35) ? ((r % 2) ? OP_INS_BACK : OP_INS_FRONT) :
                  (r < 65) ? OP_DELETE : (r < 90) ? OP_SEARCH : OP_REVERSE;
          default: op = (r < 15) ? ((r % 2) ? OP_INS_BACK : OP_INS_FRONT) :
                        (r < 70) ? OP_DELETE : (r < 90) ? OP_SEARCH : OP_REVERSE;
        endcase
        if (op == OP_SEARCH) val = pick_search();
        if (op == OP_DELETE) pos = pick_pos();
        done++;
        phase_left--;
      end
      send_req(op, val, pos);
    end

    req_ch.valid <= 1'b0;
    calm = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Requests sent: %0d insert front, %0d insert back, %0d delete, %0d search,",
             sent_by_op[OP_INS_FRONT], sent_by_op[OP_INS_BACK], sent_by_op[OP_DELETE],
             sent_by_op[OP_SEARCH]);
    $display("%0d reverse and %0d unused codes; %0d responses checked over %0d cycles.",
             sent_by_op[OP_REVERSE], sent_by_op[5] + sent_by_op[6] + sent_by_op[7],
             checked, cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("bounded_sequence_list_test: PASS");
    end else begin
      $display("bounded_sequence_list_test: FAIL");
    end
    $finish;
  end

endmodule
